/* design/smac_pkg.sv */
// ----------------------------------------------------------------------------
// smac_pkg
// Shared constants for the shadow memory access checker: shadow codes,
// opcodes, fault kinds and register indexes.
// ----------------------------------------------------------------------------
package smac_pkg;

   // granule geometry
   localparam int unsigned GRANULE_SHIFT = 3;
   localparam int unsigned GRANULE_BYTES = 8;

   // shadow byte codes
   localparam logic [7:0] SHADOW_OK      = 8'h00;
   localparam logic [7:0] SHADOW_FREED   = 8'hFB;
   localparam logic [7:0] SHADOW_REDZONE = 8'hFC;

   // opcodes
   localparam logic [1:0] OP_CHECK = 2'd0;
   localparam logic [1:0] OP_ALLOC = 2'd1;
   localparam logic [1:0] OP_FREE  = 2'd2;

   // fault kinds
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_OOB  = 2'd1;
   localparam logic [1:0] KIND_UAF  = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_ENABLE    = 2'd0;
   localparam logic [1:0] CSR_POOL_BASE = 2'd1;
   localparam logic [1:0] CSR_POOL_END  = 2'd2;

endpackage

/* design/smac_ram.sv */
// ----------------------------------------------------------------------------
// smac_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module smac_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/shadow_memory_access_checker_top.sv */
// ----------------------------------------------------------------------------
// shadow_memory_access_checker_top
// Address-sanitizer style shadow byte store with mark allocated, mark freed
// and access check operations, one shadow byte per 8-byte granule.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake             word
//   -------  ---------  --------------------  ---------------------------------
//   req      in         req_valid/req_stall   opcode, address, length,
//                                             block_bytes, is_write
//   rsp      out        rsp_valid/rsp_stall   violation, fault kind/address,
//                                             write flag, size, running total
//   csr      in         csr_write             index + 64-bit data, no readback
//
// After reset a clearing pass writes 0xFB to all SHADOW_ENTRIES entries, one
//   per cycle, with req stalled; csr writes are still taken during clearing.
// Check: one RAM read and one lane evaluation per granule touched;
//   disabled, zero-length or out-of-pool checks skip the walk.
// Mark allocated: two redzone header granules, then max(used data granules,
//   block data granules); mark freed: block_bytes/8. One shadow write per cycle.
// req_stall is high from accept until the result has been loaded into the
//   output register; a stalled rsp holds the block in its final state.
// Config must be written only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module shadow_memory_access_checker_top
   import smac_pkg::*;
#(
   parameter int unsigned SHADOW_ENTRIES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [63:0] req_address,
   input  logic [15:0] req_length,
   input  logic [15:0] req_block_bytes,
   input  logic        req_is_write,
   // response
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_violation,
   output logic [1:0]  rsp_fault_kind,
   output logic [63:0] rsp_fault_address,
   output logic        rsp_fault_is_write,
   output logic [15:0] rsp_fault_size,
   output logic [31:0] rsp_violation_total,
   // config
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   localparam int unsigned AW = $clog2(SHADOW_ENTRIES);
   localparam logic [61:0] ENTRIES_G = 62'(SHADOW_ENTRIES);
   localparam logic [AW-1:0] LAST_IDX = AW'(SHADOW_ENTRIES - 1);

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_PREP  = 7'b0000100,
      ST_FILL  = 7'b0001000,
      ST_READ  = 7'b0010000,
      ST_EVAL  = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   // ---- registers --------------------------------------------------------
   state_type   state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;

   logic        enable_ff, enable_in;
   logic [63:0] base_ff, base_in;
   logic [63:0] pend_ff, pend_in;

   // captured request word
   logic [1:0]  op_ff;
   logic [63:0] addr_ff;
   logic [15:0] len_ff;
   logic [15:0] blk_ff;
   logic        wr_ff;

   // walk state
   logic [60:0] g0_ff, g0_in;      // first data granule
   logic [61:0] cur_ff, cur_in;    // current granule, wide enough not to wrap
   logic [1:0]  hdr_ff, hdr_in;    // header granules left to write
   logic [13:0] idx_ff, idx_in;    // data granule index
   logic [13:0] fcnt_ff, fcnt_in;  // data granules to write
   logic        free_ff, free_in;  // fill with freed code
   logic [2:0]  k0_ff, k0_in;      // first byte lane in current granule
   logic [15:0] rem_ff, rem_in;    // bytes left to check
   logic [63:0] p_ff, p_in;        // address of lane k0 in current granule
   logic        viol_ff, viol_in;
   logic [1:0]  kind_ff, kind_in;
   logic [2:0]  kf_ff, kf_in;      // faulting lane

   logic [31:0] cnt_ff, cnt_in;

   // response
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_viol_ff, rsp_viol_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;
   logic [63:0] rsp_faddr_ff, rsp_faddr_in;
   logic        rsp_fwr_ff, rsp_fwr_in;
   logic [15:0] rsp_fsize_ff, rsp_fsize_in;
   logic [31:0] rsp_total_ff, rsp_total_in;

   // ---- RAM --------------------------------------------------------------
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [7:0]    ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [7:0]    ram_rd_data;

   smac_ram #(
      .WIDTH (8),
      .DEPTH (SHADOW_ENTRIES)
   ) u_shadow (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---- handshakes -------------------------------------------------------
   logic req_take;
   logic out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // ---- prep datapath: offset into pool, end address, sizes ---------------
   logic [63:0] off;
   logic [64:0] end_sum;
   logic        in_pool;
   logic [12:0] whole;
   logic [2:0]  part;
   logic [13:0] used;
   logic [12:0] data_g;
   logic [13:0] alloc_n;

   assign off     = addr_ff - base_ff;
   assign end_sum = {1'b0, addr_ff} + {49'd0, len_ff};
   assign in_pool = !(addr_ff < base_ff) && !end_sum[64] && !(end_sum[63:0] > pend_ff);
   assign whole   = len_ff[15:3];
   assign part    = len_ff[2:0];
   assign used    = {1'b0, whole} + {13'd0, (part != 3'd0)};
   assign data_g  = (blk_ff >= 16'd16) ? (blk_ff[15:3] - 13'd2) : 13'd0;
   assign alloc_n = (used > {1'b0, data_g}) ? used : {1'b0, data_g};

   // ---- fill datapath ----------------------------------------------------
   logic [61:0] hdr_g;
   logic [61:0] fill_g;
   logic [7:0]  fill_val;

   assign hdr_g  = {1'b0, g0_ff - {59'd0, hdr_ff}};
   assign fill_g = (hdr_ff != 2'd0) ? hdr_g : cur_ff;

   always_comb begin
      if (hdr_ff != 2'd0) begin
         fill_val = SHADOW_REDZONE;
      end else if (free_ff) begin
         fill_val = SHADOW_FREED;
      end else if (idx_ff < {1'b0, whole}) begin
         fill_val = SHADOW_OK;
      end else if ((idx_ff == {1'b0, whole}) && (part != 3'd0)) begin
         fill_val = {5'd0, part};
      end else begin
         fill_val = SHADOW_REDZONE;
      end
   end

   // ---- check datapath: eight byte lanes of one granule -------------------
   logic [3:0] take;
   logic       last_g;
   logic [2:0] hi;
   logic [7:0] lane_bad;
   logic       any_bad;
   logic [2:0] first_k;

   assign take   = 4'd8 - {1'b0, k0_ff};
   assign last_g = (rem_ff <= {12'd0, take});
   assign hi     = last_g ? (k0_ff + rem_ff[2:0] - 3'd1) : 3'd7;

   always_comb begin
      logic [2:0] lane;
      logic [2:0] pm;
      for (int k = 0; k < 8; k++) begin
         lane = 3'(k);
         pm   = lane + base_ff[2:0];  // absolute address bits [2:0]
         lane_bad[k] = (lane >= k0_ff) && (lane <= hi) && (ram_rd_data != SHADOW_OK) &&
                       ((ram_rd_data >= 8'd8) || ({5'd0, pm} >= ram_rd_data));
      end
      any_bad = |lane_bad;
      first_k = 3'd0;
      for (int k = 7; k >= 0; k--) begin
         if (lane_bad[k]) begin
            first_k = 3'(k);
         end
      end
   end

   // ---- sequencer --------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      g0_in    = g0_ff;
      cur_in   = cur_ff;
      hdr_in   = hdr_ff;
      idx_in   = idx_ff;
      fcnt_in  = fcnt_ff;
      free_in  = free_ff;
      k0_in    = k0_ff;
      rem_in   = rem_ff;
      p_in     = p_ff;
      viol_in  = viol_ff;
      kind_in  = kind_ff;
      kf_in    = kf_ff;
      cnt_in   = cnt_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_viol_in  = rsp_viol_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_faddr_in = rsp_faddr_ff;
      rsp_fwr_in   = rsp_fwr_ff;
      rsp_fsize_in = rsp_fsize_ff;
      rsp_total_in = rsp_total_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = cur_ff[AW-1:0];
      ram_wr_data = fill_val;
      ram_rd_en   = 1'b0;
      ram_rd_addr = cur_ff[AW-1:0];

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = SHADOW_FREED;
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            viol_in = 1'b0;
            kind_in = KIND_NONE;
            g0_in   = off[63:3];
            cur_in  = {1'b0, off[63:3]};
            idx_in  = 14'd0;
            k0_in   = off[2:0];
            rem_in  = len_ff;
            p_in    = addr_ff;
            state_in = ST_DONE;
            if (enable_ff) begin
               case (op_ff)
                  OP_ALLOC: begin
                     hdr_in   = 2'd2;
                     fcnt_in  = alloc_n;
                     free_in  = 1'b0;
                     state_in = ST_FILL;
                  end
                  OP_FREE: begin
                     hdr_in   = 2'd0;
                     fcnt_in  = {1'b0, blk_ff[15:3]};
                     free_in  = 1'b1;
                     state_in = ST_FILL;
                  end
                  OP_CHECK: begin
                     if ((len_ff != 16'd0) && in_pool) begin
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_FILL: begin
            // granules past the store are dropped
            ram_wr_addr = fill_g[AW-1:0];
            if (hdr_ff != 2'd0) begin
               ram_wr_en = (hdr_g < ENTRIES_G);
               hdr_in    = hdr_ff - 2'd1;
            end else if (idx_ff == fcnt_ff) begin
               state_in = ST_DONE;
            end else begin
               ram_wr_en = (cur_ff < ENTRIES_G);
               idx_in    = idx_ff + 14'd1;
               cur_in    = cur_ff + 62'd1;
            end
         end
         ST_READ: begin
            // granules past the store read as addressable, and so do all later ones
            if (cur_ff < ENTRIES_G) begin
               ram_rd_en = 1'b1;
               state_in  = ST_EVAL;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_EVAL: begin
            if (any_bad) begin
               viol_in  = 1'b1;
               kind_in  = (ram_rd_data == SHADOW_FREED) ? KIND_UAF : KIND_OOB;
               kf_in    = first_k;
               state_in = ST_DONE;
            end else if (last_g) begin
               state_in = ST_DONE;
            end else begin
               rem_in   = rem_ff - {12'd0, take};
               p_in     = p_ff + {60'd0, take};
               k0_in    = 3'd0;
               cur_in   = cur_ff + 62'd1;
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_viol_in  = viol_ff;
               rsp_kind_in  = viol_ff ? kind_ff : KIND_NONE;
               rsp_faddr_in = viol_ff ? (p_ff + {61'd0, kf_ff - k0_ff}) : 64'd0;
               rsp_fwr_in   = viol_ff && wr_ff;
               rsp_fsize_in = viol_ff ? len_ff : 16'd0;
               rsp_total_in = cnt_ff + {31'd0, viol_ff};
               cnt_in       = cnt_ff + {31'd0, viol_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---- config writes ----------------------------------------------------
   always_comb begin
      enable_in = enable_ff;
      base_in   = base_ff;
      pend_in   = pend_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_ENABLE:    enable_in = csr_wdata[0];
            CSR_POOL_BASE: base_in   = csr_wdata;
            CSR_POOL_END:  pend_in   = csr_wdata;
            default: begin
               enable_in = enable_ff;
            end
         endcase
      end
   end

   // ---- registers --------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         enable_ff    <= 1'b0;
         base_ff      <= 64'd0;
         pend_ff      <= 64'd0;
         cnt_ff       <= 32'd0;
         rsp_valid_ff <= 1'b0;
         viol_ff      <= 1'b0;
         hdr_ff       <= 2'd0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         enable_ff    <= enable_in;
         base_ff      <= base_in;
         pend_ff      <= pend_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         viol_ff      <= viol_in;
         hdr_ff       <= hdr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff   <= req_opcode;
         addr_ff <= req_address;
         len_ff  <= req_length;
         blk_ff  <= req_block_bytes;
         wr_ff   <= req_is_write;
      end
      g0_ff   <= g0_in;
      cur_ff  <= cur_in;
      idx_ff  <= idx_in;
      fcnt_ff <= fcnt_in;
      free_ff <= free_in;
      k0_ff   <= k0_in;
      rem_ff  <= rem_in;
      p_ff    <= p_in;
      kind_ff <= kind_in;
      kf_ff   <= kf_in;
      rsp_viol_ff  <= rsp_viol_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_faddr_ff <= rsp_faddr_in;
      rsp_fwr_ff   <= rsp_fwr_in;
      rsp_fsize_ff <= rsp_fsize_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_violation       = rsp_viol_ff;
   assign rsp_fault_kind      = rsp_kind_ff;
   assign rsp_fault_address   = rsp_faddr_ff;
   assign rsp_fault_is_write  = rsp_fwr_ff;
   assign rsp_fault_size      = rsp_fsize_ff;
   assign rsp_violation_total = rsp_total_ff;

   // ---- assertions -------------------------------------------------------
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_no_write_in_check: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ || state_ff == ST_EVAL) |-> !ram_wr_en)
      else $error("shadow write during a check walk");

   a_viol_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_viol_ff) |-> (rsp_kind_ff == KIND_OOB || rsp_kind_ff == KIND_UAF))
      else $error("violation reported with no fault kind");

   a_clean_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_viol_ff) |-> (rsp_kind_ff == KIND_NONE && rsp_faddr_ff == 64'd0))
      else $error("clean response carries fault fields");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> (cnt_ff == $past(cnt_ff) + {31'd0, $past(viol_ff)}))
      else $error("violation counter out of step");

endmodule
